// ----- hdl/sfr_pkg.sv -----
package sfr_pkg;

  // Start-of-frame byte after reset
  localparam logic [7:0] SYNC_RESET = 8'h99;
  // Fletcher modulus
  localparam logic [8:0] MOD_BASE   = 9'd255;

  // Result kinds carried on out_tuser
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  // Add two bytes modulo 255; a is already reduced, b may be 0xFF (same as 0)
  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] b_red;
    logic [8:0] s;
    b_red = (b == 8'hFF) ? 8'd0 : b;
    s     = {1'b0, a} + {1'b0, b_red};
    if (s >= MOD_BASE) begin
      s = s - MOD_BASE;
    end
    return s[7:0];
  endfunction

endpackage

// ----- hdl/serial_frame_receiver_core.sv -----
// Byte-serial frame receiver. Each accepted byte on the in_ stream drives a
// small frame parser: it hunts for the sync byte (cfg_wr_data sets it, 0x99
// after reset), takes a length byte, passes that many payload bytes through
// on the out_ stream, then reads a two-byte Fletcher-16 check (mod 255, both
// sums starting at zero, length folded in first, low byte sent first) and
// emits a good or bad verdict. One byte is taken per clock while in_tready
// is high; a result shows up on the out_ stream in the cycle after its byte
// is accepted, from a single result register. in_tready stays high while
// that register is empty or is being drained in the same cycle, so the
// throughput is one byte per cycle whenever the sink keeps out_tready high.
// Sync, length and low check bytes produce no result; the sync value must be
// changed only while no frame is in progress.
module serial_frame_receiver_core
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] data_byte, [15:8] frame_length
  output logic [1:0]  out_tuser    // [1:0] kind
);

  localparam logic [2:0] PH_SYNC    = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_CK_LO   = 3'd3;
  localparam logic [2:0] PH_CK_HI   = 3'd4;

  logic [7:0]  sync_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  sum_lo_r, sum_lo_nxt;
  logic [7:0]  sum_hi_r, sum_hi_nxt;
  logic [7:0]  ck_lo_r, ck_lo_nxt;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic [1:0]  out_kind_r;
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [7:0]  res_byte;
  logic [7:0]  fold_lo;
  logic [7:0]  left_dec;
  logic        in_acc;

  // Accept whenever the result register is free or emptying this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Running Fletcher sums for the current byte
  assign fold_lo  = add_mod255(sum_lo_r, in_tdata);
  assign left_dec = left_r - 8'd1;

  // Frame parser: next state and result for the byte at the input
  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    left_nxt      = left_r;
    sum_lo_nxt    = sum_lo_r;
    sum_hi_nxt    = sum_hi_r;
    ck_lo_nxt     = ck_lo_r;
    res_valid     = 1'b0;
    res_kind      = KIND_PAYLOAD;
    res_byte      = 8'd0;
    unique case (phase_r)
      PH_LEN: begin
        frame_len_nxt = in_tdata;
        left_nxt      = in_tdata;
        sum_lo_nxt    = add_mod255(8'd0, in_tdata);
        sum_hi_nxt    = add_mod255(8'd0, in_tdata);
        phase_nxt     = (in_tdata == 8'd0) ? PH_CK_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_lo_nxt = fold_lo;
        sum_hi_nxt = add_mod255(sum_hi_r, fold_lo);
        left_nxt   = left_dec;
        if (left_dec == 8'd0) begin
          phase_nxt = PH_CK_LO;
        end
        res_valid = 1'b1;
        res_kind  = KIND_PAYLOAD;
        res_byte  = in_tdata;
      end
      PH_CK_LO: begin
        ck_lo_nxt = in_tdata;
        phase_nxt = PH_CK_HI;
      end
      PH_CK_HI: begin
        phase_nxt = PH_SYNC;
        res_valid = 1'b1;
        res_kind  = ((ck_lo_r == sum_lo_r) && (in_tdata == sum_hi_r)) ? KIND_GOOD : KIND_BAD;
      end
      default: begin
        // hunt: drop anything that is not the sync byte
        phase_nxt = (in_tdata == sync_r) ? PH_LEN : PH_SYNC;
      end
    endcase
  end

  // Control state and sync register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r      <= SYNC_RESET;
      phase_r     <= PH_SYNC;
      frame_len_r <= 8'd0;
      left_r      <= 8'd0;
      sum_lo_r    <= 8'd0;
      sum_hi_r    <= 8'd0;
      ck_lo_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sync_r <= cfg_wr_data;
      end
      if (in_acc) begin
        phase_r     <= phase_nxt;
        frame_len_r <= frame_len_nxt;
        left_r      <= left_nxt;
        sum_lo_r    <= sum_lo_nxt;
        sum_hi_r    <= sum_hi_nxt;
        ck_lo_r     <= ck_lo_nxt;
        out_valid_r <= res_valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load with each accepted request that yields a result
  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_data_r <= {frame_len_r, res_byte};
      out_kind_r <= res_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

// ----- hdl/sfr_checker.sv -----
module sfr_checker
  import sfr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Kind is one of the three defined codes
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_PAYLOAD || out_tuser == KIND_GOOD ||
                    out_tuser == KIND_BAD))
    else $error("undefined result kind");

  // Verdicts carry a zero data byte
  a_verdict_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_PAYLOAD |-> out_tdata[7:0] == 8'd0)
    else $error("verdict with nonzero data byte");

  // An empty result register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

bind serial_frame_receiver_core sfr_checker u_sfr_checker (.*);

// ----- tb/sv/serial_frame_receiver_core_tb.sv -----
`timescale 1ns / 1ps

module serial_frame_receiver_core_tb;
  import sfr_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;

  // Parser phases of the frame predictor
  typedef enum logic [2:0] {
    HUNT_SYNC,
    TAKE_LEN,
    TAKE_PAYLOAD,
    TAKE_CK_LO,
    TAKE_CK_HI
  } rx_phase_t;

  // Ways to spoil a frame's check bytes
  typedef enum int {
    FAULT_NONE,
    FAULT_LO,
    FAULT_HI,
    FAULT_LO_FF,
    FAULT_HI_FF
  } fault_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] frame_length;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;    // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [7:0] data_byte, [15:8] frame_length
  logic [1:0]  out_tuser;           // [1:0] kind

  // Traffic control, written by the sequencer
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_holding = 1'b0;

  // Predictor state and its copy of the sync register
  logic [7:0]  sync_setting = SYNC_RESET;
  rx_phase_t   rx_phase = HUNT_SYNC;
  logic [7:0]  cur_len = 8'h00;
  logic [7:0]  bytes_left = 8'h00;
  logic [7:0]  sum_lo = 8'h00;
  logic [7:0]  sum_hi = 8'h00;
  logic [7:0]  ck_lo_rx = 8'h00;

  logic [7:0]    rx_bytes_q[$];
  frame_result_t frame_results_q[$];
  int unsigned   bytes_queued = 0;
  int unsigned   err_cnt = 0;
  int unsigned   cycle_cnt = 0;

  serial_frame_receiver_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Add a byte modulo 255; 0xFF counts as zero
  function automatic logic [7:0] fold255(input logic [7:0] acc, input logic [7:0] v);
    logic [8:0] s;
    s = {1'b0, acc} + ((v == 8'hFF) ? 9'd0 : {1'b0, v});
    return (s >= 9'd255) ? 8'(s - 9'd255) : s[7:0];
  endfunction

  // Advance the frame predictor by one received byte
  function automatic void deframe_byte(input logic [7:0] b);
    frame_result_t r;
    case (rx_phase)
      TAKE_LEN: begin
        cur_len    = b;
        bytes_left = b;
        sum_lo     = fold255(8'h00, b);
        sum_hi     = fold255(8'h00, sum_lo);
        rx_phase   = (b == 8'h00) ? TAKE_CK_LO : TAKE_PAYLOAD;
      end
      TAKE_PAYLOAD: begin
        sum_lo     = fold255(sum_lo, b);
        sum_hi     = fold255(sum_hi, sum_lo);
        bytes_left = bytes_left - 8'h01;
        if (bytes_left == 8'h00) begin
          rx_phase = TAKE_CK_LO;
        end
        r.kind         = KIND_PAYLOAD;
        r.data_byte    = b;
        r.frame_length = cur_len;
        frame_results_q.push_back(r);
      end
      TAKE_CK_LO: begin
        ck_lo_rx = b;
        rx_phase = TAKE_CK_HI;
      end
      TAKE_CK_HI: begin
        r.kind         = (ck_lo_rx == sum_lo && b == sum_hi) ? KIND_GOOD : KIND_BAD;
        r.data_byte    = 8'h00;
        r.frame_length = cur_len;
        frame_results_q.push_back(r);
        rx_phase = HUNT_SYNC;
      end
      default: begin
        rx_phase = (b == sync_setting) ? TAKE_LEN : HUNT_SYNC;
      end
    endcase
  endfunction

  // Sender: predict on each accepted byte, offer the next one unless idling
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
      end
      if (!in_tvalid || in_tready) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= rx_bytes_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted result against the oldest expectation
  always @(posedge clk) begin
    frame_result_t r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frame_results_q.size() == 0) begin
          $error("unexpected result: kind %0d data_byte %0h frame_length %0d",
                 out_tuser, out_tdata[7:0], out_tdata[15:8]);
          err_cnt++;
        end else begin
          r = frame_results_q.pop_front();
          if (out_tuser !== r.kind) begin
            $error("kind: expected %0d, got %0d", r.kind, out_tuser);
            err_cnt++;
          end
          if (out_tdata[7:0] !== r.data_byte) begin
            $error("data_byte: expected %0h, got %0h", r.data_byte, out_tdata[7:0]);
            err_cnt++;
          end
          if (out_tdata[15:8] !== r.frame_length) begin
            $error("frame_length: expected %0d, got %0d", r.frame_length, out_tdata[15:8]);
            err_cnt++;
          end
        end
      end
      out_tready <= !rx_holding && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** serial_frame_receiver_core: FAILED **");
      $finish;
    end
  end

  task automatic send(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  // Queue sync, length, payload and check bytes, spoiled as asked
  task automatic queue_frame(input int len, input fault_t fault, input int fill);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] b;
    lo = fold255(8'h00, len[7:0]);
    hi = fold255(8'h00, lo);
    send(sync_setting);
    send(len[7:0]);
    for (int i = 0; i < len; i++) begin
      b  = (fill < 0) ? 8'($urandom) : fill[7:0];
      lo = fold255(lo, b);
      hi = fold255(hi, lo);
      send(b);
    end
    case (fault)
      FAULT_LO:    lo = lo ^ 8'($urandom_range(1, 255));
      FAULT_HI:    hi = hi ^ 8'($urandom_range(1, 255));
      FAULT_LO_FF: lo = 8'hFF;
      FAULT_HI_FF: hi = 8'hFF;
      default: ;
    endcase
    send(lo);
    send(hi);
  endtask

  // Mostly whole frames with random content, some noise and cut-off frames
  task automatic queue_random(input int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    int          len;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 40);
      if (pick < 72) begin
        queue_frame(len, FAULT_NONE, -1);
      end else if (pick < 87) begin
        queue_frame(len, fault_t'($urandom_range(FAULT_LO, FAULT_HI_FF)), -1);
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 3)) send(8'($urandom));
      end else begin
        len = $urandom_range(1, 12);
        send(sync_setting);
        send(len[7:0]);
        repeat ($urandom_range(0, len - 1)) send(8'($urandom));
      end
    end
  endtask

  // Drain everything, close any open frame, then let the pipeline empty
  task automatic settle();
    forever begin
      @(negedge clk);
      while (rx_bytes_q.size() != 0 || in_tvalid || frame_results_q.size() != 0) begin
        @(negedge clk);
      end
      if (rx_phase == HUNT_SYNC) break;
      send(8'h00);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    sync_setting = v;
  endtask

  task automatic set_traffic(input int unsigned idle, input int unsigned stall);
    @(posedge clk);
    tx_idle_pct  <= idle;
    rx_stall_pct <= stall;
  endtask

  // Sequencer
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty frame, hunt noise, extreme payloads, 0xFF check bytes
    write_sync(SYNC_RESET);
    queue_frame(0, FAULT_NONE, -1);
    send(8'h00);
    send(8'hFF);
    queue_frame(1, FAULT_NONE, 8'hFF);
    queue_frame(2, FAULT_LO_FF, 8'h00);
    queue_frame(0, FAULT_HI_FF, -1);
    queue_frame(1, FAULT_HI, -1);
    settle();

    // No idling; hold the receiver off long enough to back up the input
    write_sync(8'h00);
    set_traffic(0, 0);
    queue_random(50);
    @(posedge clk);
    rx_holding <= 1'b1;
    repeat (300) @(posedge clk);
    rx_holding <= 1'b0;
    settle();

    // Sender idles most cycles
    write_sync(8'hFF);
    set_traffic(60, 0);
    queue_random(40);
    settle();

    // Receiver stalls most cycles
    write_sync(8'($urandom));
    set_traffic(0, 60);
    queue_random(40);
    settle();

    // Light idling on both sides, including a full-length frame
    write_sync(8'($urandom));
    set_traffic(7, 7);
    queue_random(10);
    queue_frame(255, FAULT_NONE, -1);
    settle();

    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** serial_frame_receiver_core: PASSED **");
    end else begin
      $display("** serial_frame_receiver_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sfr_pkg.sv
hdl/serial_frame_receiver_core.sv
hdl/sfr_checker.sv
tb/sv/serial_frame_receiver_core_tb.sv
